/* hdl/svbg_pkg.sv */
package svbg_pkg;

  localparam int unsigned NumBands = 7;
  localparam int unsigned LinDiv   = 31;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGate = 1'b1;

  localparam logic [2:0] ModeLinOne   = 3'd0;
  localparam logic [2:0] ModeLinAll   = 3'd1;
  localparam logic [2:0] ModeStanding = 3'd2;
  localparam logic [2:0] ModeFloor    = 3'd3;
  localparam logic [2:0] ModeLogLin   = 3'd4;
  localparam logic [2:0] ModeLogOne   = 3'd5;
  localparam logic [2:0] ModeLogAll   = 3'd6;
  localparam logic [2:0] ModeNone     = 3'd7;

  localparam logic [2:0] GateReset = 3'd0;
  localparam logic [7:0] ThrReset  = 8'd18;

  localparam logic [7:0] LogSteps [8] = '{2, 4, 8, 16, 31, 63, 125, 250};
  localparam logic [2:0] Col0Y [8] = '{0, 0, 1, 2, 2, 3, 4, 4};
  localparam logic [2:0] FloorMap [8][8] = '{
    '{0, 0, 1, 1, 2, 2, 3, 3},
    '{0, 1, 1, 2, 2, 3, 3, 4},
    '{1, 1, 2, 2, 3, 3, 4, 4},
    '{2, 2, 2, 3, 3, 4, 4, 5},
    '{2, 2, 3, 3, 4, 4, 5, 5},
    '{3, 3, 3, 4, 4, 5, 5, 6},
    '{3, 3, 4, 4, 5, 5, 6, 6},
    '{4, 4, 5, 5, 5, 6, 6, 6}
  };

  typedef logic [NumBands-1:0][7:0] bands_t;
  typedef logic [7:0][63:0] frame_t;

  typedef struct packed {
    logic [NumBands-1:0][7:0] lin;
    logic [NumBands-1:0][7:0] lg;
    logic [7:0]               c0_lin;
    logic [7:0]               c0_log;
  } bars_t;

  function automatic logic [3:0] lin_height(logic [7:0] lv);
    logic [3:0] h;
    h = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (lv >= 8'(LinDiv * k)) h = h + 4'd1;
    end
    return h;
  endfunction

  function automatic logic [3:0] log_height(logic [7:0] lv);
    logic [3:0] h;
    h = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (lv > LogSteps[k]) h = h + 4'd1;
    end
    return h;
  endfunction

  function automatic logic [7:0] bar_mask(logic [3:0] h);
    logic [7:0] m;
    for (int k = 0; k < 8; k++) begin
      m[k] = (4'(k) < h);
    end
    return m;
  endfunction

  function automatic logic [7:0] col0_mask(logic [3:0] h);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < h) m[Col0Y[k]] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [63:0] upright(logic [NumBands-1:0][7:0] bm, logic [7:0] c0);
    logic [63:0] l;
    for (int y = 0; y < 8; y++) begin
      l[y*8] = c0[y];
      for (int i = 0; i < NumBands; i++) begin
        l[y*8+i+1] = bm[i][y];
      end
    end
    return l;
  endfunction

endpackage

/* hdl/svbg_band_if.sv */
interface svbg_band_if;
  logic       valid;
  logic       ready;
  logic [7:0] band_0;
  logic [7:0] band_1;
  logic [7:0] band_2;
  logic [7:0] band_3;
  logic [7:0] band_4;
  logic [7:0] band_5;
  logic [7:0] band_6;

  modport source (
    output valid, band_0, band_1, band_2, band_3, band_4, band_5, band_6,
    input  ready
  );
  modport sink (
    input  valid, band_0, band_1, band_2, band_3, band_4, band_5, band_6,
    output ready
  );
endinterface

/* hdl/svbg_layer_if.sv */
interface svbg_layer_if;
  logic        valid;
  logic        ready;
  logic [2:0]  layer_index;
  logic [63:0] layer_bits;
  logic        last_layer;

  modport source (
    output valid, layer_index, layer_bits, last_layer,
    input  ready
  );
  modport sink (
    input  valid, layer_index, layer_bits, last_layer,
    output ready
  );
endinterface

/* hdl/svbg_bars.sv */
module svbg_bars (
  input  svbg_pkg::bands_t bands_i,
  input  logic [7:0]       thr_i,
  output svbg_pkg::bars_t  bars_o
);

  logic [10:0]      sum;
  logic [10:0]      thr7;
  logic             gated;
  svbg_pkg::bands_t lv;

  always_comb begin
    sum = '0;
    for (int i = 0; i < svbg_pkg::NumBands; i++) begin
      sum = sum + 11'(bands_i[i]);
    end
    // floor(sum/7) < thr is the same as sum < 7*thr
    thr7  = {thr_i, 3'b000} - 11'(thr_i);
    gated = (sum < thr7);
    lv    = gated ? '0 : bands_i;
    for (int i = 0; i < svbg_pkg::NumBands; i++) begin
      bars_o.lin[i] = svbg_pkg::bar_mask(svbg_pkg::lin_height(lv[i]));
      bars_o.lg[i]  = svbg_pkg::bar_mask(svbg_pkg::log_height(lv[i]));
    end
    bars_o.c0_lin = svbg_pkg::col0_mask(svbg_pkg::lin_height(lv[0]));
    bars_o.c0_log = svbg_pkg::col0_mask(svbg_pkg::log_height(lv[0]));
  end

endmodule

/* hdl/svbg_layers.sv */
module svbg_layers (
  input  logic [2:0]       mode_i,
  input  svbg_pkg::bars_t  bars_i,
  output svbg_pkg::frame_t frame_o
);

  logic [63:0] up_lin;
  logic [63:0] up_log;

  assign up_lin = svbg_pkg::upright(bars_i.lin, bars_i.c0_lin);
  assign up_log = svbg_pkg::upright(bars_i.lg, bars_i.c0_log);

  always_comb begin
    frame_o = '0;
    unique case (mode_i)
      svbg_pkg::ModeLinOne: frame_o[7] = up_lin;
      svbg_pkg::ModeLinAll: begin
        for (int z = 0; z < 8; z++) frame_o[z] = up_lin;
      end
      svbg_pkg::ModeStanding: begin
        for (int z = 0; z < 8; z++) begin
          for (int r = 2; r < 6; r++) begin
            frame_o[z][r*8] = bars_i.c0_lin[z];
            for (int i = 0; i < svbg_pkg::NumBands; i++) begin
              frame_o[z][r*8+i+1] = bars_i.lin[i][z];
            end
          end
        end
      end
      svbg_pkg::ModeFloor: begin
        for (int x = 0; x < 8; x++) begin
          for (int z = 0; z < 8; z++) begin
            for (int y = 0; y < 8; y++) begin
              frame_o[z][y*8+x] = bars_i.lin[svbg_pkg::FloorMap[x][z]][y];
            end
          end
        end
      end
      svbg_pkg::ModeLogLin: begin
        frame_o[2] = up_log;
        frame_o[5] = up_lin;
      end
      svbg_pkg::ModeLogOne: frame_o[7] = up_log;
      svbg_pkg::ModeLogAll: begin
        for (int z = 0; z < 8; z++) frame_o[z] = up_log;
      end
      default: frame_o = '0;
    endcase
  end

endmodule

/* hdl/svbg_emit.sv */
module svbg_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  output logic             load_ready_o,
  input  svbg_pkg::frame_t frame_i,
  svbg_layer_if.source     layer_o
);

  logic             vld_q;
  logic [2:0]       cnt_q;
  svbg_pkg::frame_t frame_q;
  logic             beat;
  logic             last;
  logic             load;

  assign last         = (cnt_q == 3'd7);
  assign beat         = vld_q && layer_o.ready;
  assign load_ready_o = !vld_q || (beat && last);
  assign load         = load_valid_i && load_ready_o;

  assign layer_o.valid       = vld_q;
  assign layer_o.layer_index = cnt_q;
  assign layer_o.layer_bits  = frame_q[0];
  assign layer_o.last_layer  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else if (load) begin
      vld_q <= 1'b1;
      cnt_q <= '0;
    end else if (beat) begin
      vld_q <= !last;
      cnt_q <= cnt_q + 3'd1;
    end
  end

  // the layer being offered always sits at the bottom of the frame register
  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end else if (beat) begin
      frame_q <= {64'b0, frame_q[7:1]};
    end
  end

endmodule

/* hdl/spectrum_to_voxel_bar_graph.sv */
// Spectrum bar graph for an 8x8x8 voxel cube. Each input beat carries seven
// band levels and yields one frame of eight output beats, layers 0 to 7 in
// order with last_layer on layer 7; mode 7 yields no beats. The frame is
// computed combinationally from an input register into a frame register, so
// the output port sets the pace, with the next input beat already taken while
// a frame drains. An input beat passes through the input register and
// then the frame register before its first layer is offered. Write mode
// and gate_threshold only while the block is idle.
module spectrum_to_voxel_bar_graph (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [svbg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [svbg_pkg::CfgDataW-1:0]   cfg_wdata_i,
  svbg_band_if.sink                       band_i,
  svbg_layer_if.source                    layer_o
);

  logic [2:0]       mode_q;
  logic [7:0]       thr_q;
  logic             in_vld_q;
  svbg_pkg::bands_t bands_q;
  logic             advance;
  logic             load_valid;
  logic             load_ready;
  svbg_pkg::bars_t  bars;
  svbg_pkg::frame_t frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= svbg_pkg::GateReset;
      thr_q  <= svbg_pkg::ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svbg_pkg::CfgMode: mode_q <= cfg_wdata_i[2:0];
        svbg_pkg::CfgGate: thr_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign load_valid   = in_vld_q && (mode_q != svbg_pkg::ModeNone);
  assign advance      = in_vld_q && (load_ready || (mode_q == svbg_pkg::ModeNone));
  assign band_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (band_i.valid && band_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (band_i.valid && band_i.ready) begin
      bands_q <= {band_i.band_6, band_i.band_5, band_i.band_4, band_i.band_3,
                  band_i.band_2, band_i.band_1, band_i.band_0};
    end
  end

  svbg_bars u_bars (
    .bands_i (bands_q),
    .thr_i   (thr_q),
    .bars_o  (bars)
  );

  svbg_layers u_layers (
    .mode_i  (mode_q),
    .bars_i  (bars),
    .frame_o (frame)
  );

  svbg_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (load_valid),
    .load_ready_o (load_ready),
    .frame_i      (frame),
    .layer_o      (layer_o)
  );

  a_layer_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (layer_o.valid && layer_o.ready && !layer_o.last_layer) |=>
      (layer_o.valid && layer_o.layer_index == $past(layer_o.layer_index) + 3'd1))
    else $error("layer sequence broken inside a frame");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (layer_o.valid && layer_o.ready && layer_o.last_layer) |=>
      (!layer_o.valid || layer_o.layer_index == 3'd0))
    else $error("new frame does not start at layer zero");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && layer_o.valid && !(layer_o.ready && layer_o.last_layer) &&
     mode_q != svbg_pkg::ModeNone) |-> !band_i.ready)
    else $error("input taken while the held item cannot move on");

endmodule

/* verif/svbg_checker.sv */
module svbg_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svbg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [svbg_pkg::CfgDataW-1:0] cfg_wdata_i,
  svbg_band_if                          band_mon,
  svbg_layer_if                         layer_mon,
  output int unsigned                   err_cnt_o,
  output int unsigned                   open_cnt_o,
  output int unsigned                   frame_cnt_o,
  output int unsigned                   gated_cnt_o,
  output int unsigned                   layer_cnt_o,
  output logic [7:0]                    modes_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  idx;
    logic [63:0] bits;
    logic        last;
  } layer_beat_t;

  localparam int unsigned Steps [8] = '{2, 4, 8, 16, 31, 63, 125, 250};

  // band owning floor column, indexed [x][z]
  localparam int unsigned ColBand [8][8] = '{
    '{0, 0, 1, 1, 2, 2, 3, 3},
    '{0, 1, 1, 2, 2, 3, 3, 4},
    '{1, 1, 2, 2, 3, 3, 4, 4},
    '{2, 2, 2, 3, 3, 4, 4, 5},
    '{2, 2, 3, 3, 4, 4, 5, 5},
    '{3, 3, 3, 4, 4, 5, 5, 6},
    '{3, 3, 4, 4, 5, 5, 6, 6},
    '{4, 4, 5, 5, 5, 6, 6, 6}
  };

  logic [2:0]        mode_q;
  logic [7:0]        thr_q;
  layer_beat_t       layers_due [$];
  layer_beat_t       want;
  svbg_pkg::frame_t  fr;
  svbg_pkg::bands_t  beat_bands;
  bit                gated;

  function automatic int unsigned bar_top(input int unsigned lv, input bit logscale);
    int unsigned n;
    n = 0;
    if (!logscale) return lv / 31;
    while (n < 8 && lv > Steps[n]) n++;
    return n;
  endfunction

  function automatic void paint_bars(inout svbg_pkg::frame_t f,
                                     input int unsigned lv [svbg_pkg::NumBands],
                                     input int unsigned zz, input bit logscale,
                                     input bit upright);
    int unsigned top;
    for (int unsigned i = 0; i < svbg_pkg::NumBands; i++) begin
      top = bar_top(lv[i], logscale);
      for (int unsigned h = 0; h < top; h++) begin
        if (upright) begin
          if (i == 0) f[zz][(h * 10 / 15) * 8] = 1'b1;
          f[zz][h * 8 + i + 1] = 1'b1;
        end else begin
          if (i == 0) f[h * 10 / 15][zz * 8] = 1'b1;
          f[h][zz * 8 + i + 1] = 1'b1;
        end
      end
    end
  endfunction

  function automatic svbg_pkg::frame_t draw_frame(input svbg_pkg::bands_t b,
                                                  input logic [2:0] m,
                                                  input logic [7:0] thr, output bit blank);
    svbg_pkg::frame_t f;
    int unsigned      lv [svbg_pkg::NumBands];
    int unsigned      total;
    int unsigned      top;
    f = '0;
    total = 0;
    for (int unsigned i = 0; i < svbg_pkg::NumBands; i++) begin
      lv[i] = b[i];
      total += lv[i];
    end
    blank = (total / 7) < thr;
    if (blank) begin
      for (int unsigned i = 0; i < svbg_pkg::NumBands; i++) lv[i] = 0;
    end
    case (m)
      svbg_pkg::ModeLinOne: paint_bars(f, lv, 7, 1'b0, 1'b1);
      svbg_pkg::ModeLinAll: begin
        for (int unsigned z = 0; z < 8; z++) paint_bars(f, lv, z, 1'b0, 1'b1);
      end
      svbg_pkg::ModeStanding: begin
        for (int unsigned s = 2; s < 6; s++) paint_bars(f, lv, s, 1'b0, 1'b0);
      end
      svbg_pkg::ModeFloor: begin
        for (int unsigned x = 0; x < 8; x++) begin
          for (int unsigned z = 0; z < 8; z++) begin
            top = lv[ColBand[x][z]] / 31;
            for (int unsigned y = 0; y < top && y < 8; y++) f[z][y * 8 + x] = 1'b1;
          end
        end
      end
      svbg_pkg::ModeLogLin: begin
        paint_bars(f, lv, 2, 1'b1, 1'b1);
        paint_bars(f, lv, 5, 1'b0, 1'b1);
      end
      svbg_pkg::ModeLogOne: paint_bars(f, lv, 7, 1'b1, 1'b1);
      default: begin
        for (int unsigned z = 0; z < 8; z++) paint_bars(f, lv, z, 1'b1, 1'b1);
      end
    endcase
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = svbg_pkg::ModeLinOne;
      thr_q = svbg_pkg::ThrReset;
      layers_due.delete();
      err_cnt_o = 0;
      open_cnt_o = 0;
      frame_cnt_o = 0;
      gated_cnt_o = 0;
      layer_cnt_o = 0;
      modes_seen_o = '0;
    end else begin
      if (layer_mon.valid && layer_mon.ready) begin
        layer_cnt_o++;
        if (layers_due.size() == 0) begin
          $error("layer beat with no frame due: layer_index %0d layer_bits %h",
                 layer_mon.layer_index, layer_mon.layer_bits);
          err_cnt_o++;
        end else begin
          want = layers_due.pop_front();
          if (layer_mon.layer_index !== want.idx) begin
            $error("layer_index expected %0d got %0d", want.idx, layer_mon.layer_index);
            err_cnt_o++;
          end
          if (layer_mon.layer_bits !== want.bits) begin
            $error("layer_bits expected %h got %h (layer %0d)", want.bits,
                   layer_mon.layer_bits, want.idx);
            err_cnt_o++;
          end
          if (layer_mon.last_layer !== want.last) begin
            $error("last_layer expected %0b got %0b (layer %0d)", want.last,
                   layer_mon.last_layer, want.idx);
            err_cnt_o++;
          end
        end
      end
      if (band_mon.valid && band_mon.ready) begin
        beat_bands = {band_mon.band_6, band_mon.band_5, band_mon.band_4, band_mon.band_3,
                      band_mon.band_2, band_mon.band_1, band_mon.band_0};
        modes_seen_o[mode_q] = 1'b1;
        if (mode_q != svbg_pkg::ModeNone) begin
          fr = draw_frame(beat_bands, mode_q, thr_q, gated);
          frame_cnt_o++;
          if (gated) gated_cnt_o++;
          for (int unsigned z = 0; z < 8; z++) begin
            layers_due.push_back('{idx: 3'(z), bits: fr[z], last: (z == 7)});
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == svbg_pkg::CfgMode) mode_q = cfg_wdata_i[2:0];
        else if (cfg_idx_i == svbg_pkg::CfgGate) thr_q = cfg_wdata_i;
      end
      open_cnt_o = layers_due.size();
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 8;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [svbg_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [svbg_pkg::CfgDataW-1:0] cfg_wdata;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned quiet_cycles;
  int unsigned beats_sent;
  logic [7:0]  cur_thr;

  int unsigned err_cnt;
  int unsigned open_cnt;
  int unsigned frame_cnt;
  int unsigned gated_cnt;
  int unsigned layer_cnt;
  logic [7:0]  modes_seen;

  svbg_band_if  band_bus ();
  svbg_layer_if layer_bus ();

  spectrum_to_voxel_bar_graph i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .band_i      (band_bus),
    .layer_o     (layer_bus)
  );

  svbg_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .band_mon     (band_bus),
    .layer_mon    (layer_bus),
    .err_cnt_o    (err_cnt),
    .open_cnt_o   (open_cnt),
    .frame_cnt_o  (frame_cnt),
    .gated_cnt_o  (gated_cnt),
    .layer_cnt_o  (layer_cnt),
    .modes_seen_o (modes_seen)
  );

  initial clk_i = 1'b0;
  always #10ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    layer_bus.ready <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
  end

  // no beat on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((band_bus.valid && band_bus.ready) || (layer_bus.valid && layer_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d layers outstanding",
                 quiet_cycles, open_cnt);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic svbg_pkg::bands_t mk(input int a0, input int a1, input int a2,
                                          input int a3, input int a4, input int a5,
                                          input int a6);
    return {8'(a6), 8'(a5), 8'(a4), 8'(a3), 8'(a2), 8'(a1), 8'(a0)};
  endfunction

  function automatic logic [7:0] rand_level();
    int unsigned k;
    k = $urandom_range(8);
    case ($urandom_range(5))
      0: return 8'(31 * k) - 8'($urandom_range(1));
      1: return svbg_pkg::LogSteps[k % 8] + 8'($urandom_range(1));
      2: return 8'd0;
      3: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic svbg_pkg::bands_t rand_bands(input logic [7:0] thr);
    svbg_pkg::bands_t b;
    int unsigned      pick;
    pick = $urandom_range(9);
    for (int i = 0; i < svbg_pkg::NumBands; i++) begin
      if (pick < 6) b[i] = rand_level();
      else if (pick < 8) b[i] = 8'($urandom_range(255, 160));
      else b[i] = thr - 8'(pick - 8);
    end
    return b;
  endfunction

  task automatic send_bands(input svbg_pkg::bands_t b);
    logic rdy;
    while ($urandom_range(99) < src_idle_pct) begin
      band_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    band_bus.valid  <= 1'b1;
    band_bus.band_0 <= b[0];
    band_bus.band_1 <= b[1];
    band_bus.band_2 <= b[2];
    band_bus.band_3 <= b[3];
    band_bus.band_4 <= b[4];
    band_bus.band_5 <= b[5];
    band_bus.band_6 <= b[6];
    do begin
      @(negedge clk_i);
      rdy = band_bus.ready;
      @(posedge clk_i);
    end while (!rdy);
    beats_sent++;
  endtask

  task automatic wait_empty();
    band_bus.valid <= 1'b0;
    do @(negedge clk_i); while (open_cnt != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [svbg_pkg::CfgIdxW-1:0] idx,
                           input logic [svbg_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_cfg(input logic [2:0] m, input logic [7:0] thr);
    wait_empty();
    write_reg(svbg_pkg::CfgMode, svbg_pkg::CfgDataW'(m));
    write_reg(svbg_pkg::CfgGate, thr);
    cur_thr = thr;
  endtask

  initial begin
    logic [2:0] m;
    logic [7:0] thr;
    band_bus.valid  <= 1'b0;
    band_bus.band_0 <= '0;
    band_bus.band_1 <= '0;
    band_bus.band_2 <= '0;
    band_bus.band_3 <= '0;
    band_bus.band_4 <= '0;
    band_bus.band_5 <= '0;
    band_bus.band_6 <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    rst_ni          <= 1'b0;
    beats_sent      = 0;
    src_idle_pct    = 25;
    sink_idle_pct   = 66;
    cur_thr         = svbg_pkg::ThrReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: linear bars in the top layer, default gate
    send_bands(mk(0, 0, 0, 0, 0, 0, 0));
    send_bands(mk(255, 255, 255, 255, 255, 255, 255));
    send_bands(mk(30, 31, 61, 62, 92, 93, 124));
    send_bands(mk(124, 0, 0, 0, 0, 0, 1));
    send_bands(mk(124, 0, 0, 0, 0, 0, 2));

    // zero threshold never gates
    set_cfg(svbg_pkg::ModeLinAll, 8'd0);
    send_bands(mk(31, 0, 0, 0, 0, 0, 0));
    send_bands(mk(255, 217, 186, 155, 124, 93, 62));

    set_cfg(svbg_pkg::ModeStanding, 8'd0);
    send_bands(mk(255, 255, 255, 255, 255, 255, 255));
    send_bands(mk(62, 93, 124, 155, 186, 217, 248));

    set_cfg(svbg_pkg::ModeFloor, 8'd255);
    send_bands(mk(255, 255, 255, 255, 255, 255, 255));
    send_bands(mk(255, 255, 255, 255, 255, 255, 254));

    // log thresholds on both sides of each step
    set_cfg(svbg_pkg::ModeLogLin, svbg_pkg::ThrReset);
    send_bands(mk(2, 3, 4, 5, 250, 251, 255));
    send_bands(mk(8, 9, 16, 17, 31, 32, 63));

    set_cfg(svbg_pkg::ModeLogOne, 8'd0);
    send_bands(mk(64, 125, 126, 250, 251, 1, 0));

    // gate applies to log bars as well
    set_cfg(svbg_pkg::ModeLogAll, 8'd100);
    send_bands(mk(255, 251, 126, 64, 32, 17, 9));
    send_bands(mk(3, 3, 3, 3, 3, 3, 3));

    // unused mode draws nothing
    set_cfg(svbg_pkg::ModeNone, 8'd0);
    send_bands(mk(255, 255, 255, 255, 255, 255, 255));
    send_bands(mk(31, 62, 93, 124, 155, 186, 217));

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 66 : 0;
      sink_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 25 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        m = 3'($urandom_range(6));
        if ($urandom_range(9) == 0) m = svbg_pkg::ModeNone;
        case ($urandom_range(4))
          0: thr = 8'd0;
          1: thr = 8'd255;
          2: thr = svbg_pkg::ThrReset;
          3: thr = 8'($urandom_range(60));
          default: thr = 8'($urandom_range(255));
        endcase
        set_cfg(m, thr);
        for (int n = 0; n < 30; n++) begin
          if ($urandom_range(49) == 0) wait_empty();
          send_bands(rand_bands(cur_thr));
        end
      end
    end

    wait_empty();
    repeat (16) @(posedge clk_i);
    $display("summary: %0d band beats sent, %0d frames predicted (%0d gated)",
             beats_sent, frame_cnt, gated_cnt);
    $display("summary: %0d layers checked, modes seen %b, gate thresholds 0 to 255, %s",
             layer_cnt, modes_seen, "three stall patterns");
    if (err_cnt == 0 && open_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/svbg_pkg.sv
hdl/svbg_band_if.sv
hdl/svbg_layer_if.sv
hdl/svbg_bars.sv
hdl/svbg_layers.sv
hdl/svbg_emit.sv
hdl/spectrum_to_voxel_bar_graph.sv
verif/svbg_checker.sv
verif/testbench.sv
